FILE: hw/rtl/job_scheduler_select_unit_assert.svh
// Assertion macros shared by the checker of the job scheduler select unit.
`ifndef JOB_SCHEDULER_SELECT_UNIT_ASSERT_SVH
`define JOB_SCHEDULER_SELECT_UNIT_ASSERT_SVH
`define JSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jss check failed");
`define JSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jss check failed");
`endif

FILE: hw/rtl/jss_pkg.sv
`timescale 1ns / 1ps
package jss_pkg;
  localparam int MaxJobs = 16;
  localparam int SlotW = $clog2(MaxJobs);
  localparam int CntW = $clog2(MaxJobs + 1);

  localparam logic [1:0] CMD_NEW = 2'd0;
  localparam logic [1:0] CMD_QUANTUM = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_PRI = 3'd1;
  localparam logic [2:0] POL_PPRI = 3'd2;
  localparam logic [2:0] POL_SRTF = 3'd3;
  localparam logic [2:0] POL_RR = 3'd4;
  localparam logic [2:0] POL_SJF = 3'd5;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] prio;
    logic [31:0] arrival;
    logic        started;
    logic [31:0] first_run;
    logic [31:0] elapsed;
    logic [31:0] mark;
    logic [31:0] runtime;
  } slot_t;

  localparam int SlotBits = $bits(slot_t);
endpackage

FILE: hw/rtl/job_scheduler_select_unit.sv
`timescale 1ns / 1ps
// Job scheduler select unit: a job table with a dispatcher for six schemes.
// Input requests (in_*) carry a command with its job fields under valid/stall.
// Each accepted request yields exactly one result request on out_* with the
// status, the chosen job and the running totals of finished jobs.
// The cfg_ channel writes the policy register and is only used while idle.
// The slot table lives in one RAM with registered read. A tag lookup walks
// all slots one per cycle, and a dispatch walks all slots one per cycle with
// one key comparator over the queued ones. One request is handled at a time.
// The result sits in an output register; the next request is accepted while
// the result waits, but its own result is held back until the receiver takes
// the earlier one. Reset clears the used and queued bits, the totals and the
// policy; slot contents stay undefined until a job is inserted.
module job_scheduler_select_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_job_tag,
  input  logic        in_tag_valid,
  input  logic [31:0] in_now,
  input  logic [15:0] in_prio_in,
  input  logic [31:0] in_expected_run,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_run_valid,
  output logic [15:0] out_run_tag,
  output logic [31:0] out_finished_count,
  output logic signed [47:0] out_wait_total,
  output logic signed [47:0] out_turnaround_total,
  output logic signed [47:0] out_response_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);
  localparam int SW = jss_pkg::SlotW;
  localparam int CW = jss_pkg::CntW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FIND = 4'd1;
  localparam logic [3:0] S_FWAIT = 4'd2;
  localparam logic [3:0] S_EVUPD = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_SWAIT = 4'd5;
  localparam logic [3:0] S_DISP = 4'd6;
  localparam logic [3:0] S_DWAIT = 4'd7;
  localparam logic [3:0] S_FIN = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [2:0] policy_r;
  logic [jss_pkg::MaxJobs-1:0] used_r, used_nxt, queued_r, queued_nxt;
  logic [1:0] cmd_r;
  logic [15:0] tag_r;
  logic [31:0] now_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic found_r, found_nxt;
  logic [SW-1:0] hit_r, hit_nxt;
  logic best_ok_r, best_ok_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic signed [32:0] bkey_r, bkey_nxt;
  logic [31:0] barr_r, barr_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic res_rv_r, res_rv_nxt;
  logic [15:0] res_tag_r, res_tag_nxt;
  logic [31:0] done_r, done_nxt;
  logic [47:0] wsum_r, wsum_nxt, tsum_r, tsum_nxt, rsum_r, rsum_nxt;
  logic ov_r, ov_nxt;
  logic [1:0] ostat_r;
  logic orv_r;
  logic [15:0] otag_r;
  logic [31:0] ocnt_r;
  logic [47:0] owsum_r, otsum_r, orsum_r;

  logic we;
  logic [SW-1:0] waddr, raddr;
  jss_pkg::slot_t wdata, rdata;

  jss_ram #(.Width(jss_pkg::SlotBits), .Depth(jss_pkg::MaxJobs)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic take;
  logic load_out;
  logic [SW-1:0] free_idx;
  logic free_ok;
  logic signed [32:0] key;
  logic [SW-1:0] prev;
  logic preempt;

  assign in_stall = (state_r != S_IDLE);
  assign take = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_OUT) && (!ov_r || !out_stall);
  assign out_valid = ov_r;
  assign out_status = ostat_r;
  assign out_run_valid = orv_r;
  assign out_run_tag = otag_r;
  assign out_finished_count = ocnt_r;
  assign out_wait_total = owsum_r;
  assign out_turnaround_total = otsum_r;
  assign out_response_total = orsum_r;
  assign prev = SW'(cnt_r - CW'(1));
  assign preempt = (policy_r == jss_pkg::POL_PPRI) || (policy_r == jss_pkg::POL_SRTF) ||
                   (policy_r == jss_pkg::POL_RR);

  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = jss_pkg::MaxJobs - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_ok = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    case (policy_r)
      jss_pkg::POL_PRI, jss_pkg::POL_PPRI: key = {17'd0, rdata.prio};
      jss_pkg::POL_SRTF: key = {1'b0, rdata.runtime} - {1'b0, rdata.elapsed};
      jss_pkg::POL_RR: key = {1'b0, rdata.elapsed};
      jss_pkg::POL_SJF: key = {1'b0, rdata.runtime};
      default: key = {1'b0, rdata.arrival};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    queued_nxt = queued_r;
    cnt_nxt = cnt_r;
    found_nxt = found_r;
    hit_nxt = hit_r;
    best_ok_nxt = best_ok_r;
    best_nxt = best_r;
    bkey_nxt = bkey_r;
    barr_nxt = barr_r;
    res_status_nxt = res_status_r;
    res_rv_nxt = res_rv_r;
    res_tag_nxt = res_tag_r;
    done_nxt = done_r;
    wsum_nxt = wsum_r;
    tsum_nxt = tsum_r;
    rsum_nxt = rsum_r;
    ov_nxt = ov_r && out_stall;
    we = 1'b0;
    waddr = hit_r;
    wdata = rdata;
    raddr = SW'(cnt_r);
    case (state_r)
      S_IDLE: begin
        if (take) begin
          res_status_nxt = jss_pkg::ST_OK;
          res_rv_nxt = 1'b0;
          res_tag_nxt = '0;
          cnt_nxt = '0;
          found_nxt = 1'b0;
          best_ok_nxt = 1'b0;
          raddr = '0;
          case (in_command)
            jss_pkg::CMD_NEW: begin
              if (!free_ok) begin
                res_status_nxt = jss_pkg::ST_FULL;
              end else begin
                used_nxt[free_idx] = 1'b1;
                queued_nxt[free_idx] = 1'b1;
                we = 1'b1;
                waddr = free_idx;
                wdata.tag = in_job_tag;
                wdata.prio = in_prio_in;
                wdata.arrival = in_now;
                wdata.started = 1'b0;
                wdata.first_run = '0;
                wdata.elapsed = '0;
                wdata.mark = in_now;
                wdata.runtime = in_expected_run;
              end
              state_nxt = S_OUT;
            end
            jss_pkg::CMD_QUANTUM: state_nxt = in_tag_valid ? S_FIND : S_SCAN;
            jss_pkg::CMD_FINISH: state_nxt = S_FIND;
            default: state_nxt = S_OUT;
          endcase
          raddr = '0;
          cnt_nxt = CW'(1);
        end
      end
      S_FIND: begin
        if (!found_r && used_r[prev] && rdata.tag == tag_r) begin
          found_nxt = 1'b1;
          hit_nxt = prev;
        end
        if (cnt_r == CW'(jss_pkg::MaxJobs)) begin
          state_nxt = S_FWAIT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_FWAIT: begin
        raddr = hit_r;
        if (!found_r) begin
          res_status_nxt = jss_pkg::ST_NOTFOUND;
          state_nxt = S_OUT;
        end else begin
          state_nxt = (cmd_r == jss_pkg::CMD_FINISH) ? S_FIN : S_EVUPD;
        end
      end
      S_EVUPD: begin
        we = 1'b1;
        wdata.elapsed = rdata.elapsed + (now_r - rdata.mark);
        wdata.mark = now_r;
        if (!preempt) begin
          res_rv_nxt = 1'b1;
          res_tag_nxt = rdata.tag;
          state_nxt = S_OUT;
        end else begin
          queued_nxt[hit_r] = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r == '0) begin
          cnt_nxt = CW'(1);
        end else begin
          if (used_r[prev] && queued_r[prev]) begin
            if (!best_ok_r || key < bkey_r || (key == bkey_r && rdata.arrival < barr_r)) begin
              best_ok_nxt = 1'b1;
              best_nxt = prev;
              bkey_nxt = key;
              barr_nxt = rdata.arrival;
            end
          end
          if (cnt_r == CW'(jss_pkg::MaxJobs)) begin
            state_nxt = S_SWAIT;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      S_SWAIT: begin
        raddr = best_r;
        state_nxt = best_ok_r ? S_DISP : S_OUT;
      end
      S_DISP: begin
        we = 1'b1;
        waddr = best_r;
        queued_nxt[best_r] = 1'b0;
        if (!rdata.started) begin
          wdata.started = 1'b1;
          wdata.first_run = now_r;
        end
        wdata.mark = now_r;
        res_rv_nxt = 1'b1;
        res_tag_nxt = rdata.tag;
        state_nxt = S_OUT;
      end
      S_FIN: begin
        used_nxt[hit_r] = 1'b0;
        queued_nxt[hit_r] = 1'b0;
        done_nxt = done_r + 32'd1;
        wsum_nxt = wsum_r + 48'(now_r) - 48'(rdata.arrival) - 48'(rdata.runtime);
        tsum_nxt = tsum_r + 48'(now_r) - 48'(rdata.arrival);
        rsum_nxt = rsum_r - 48'(rdata.arrival) +
                   (rdata.started ? 48'(rdata.first_run) : {48{1'b1}});
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      policy_r <= jss_pkg::POL_FCFS;
      used_r <= '0;
      queued_r <= '0;
      ov_r <= 1'b0;
      done_r <= '0;
      wsum_r <= '0;
      tsum_r <= '0;
      rsum_r <= '0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      queued_r <= queued_nxt;
      ov_r <= ov_nxt;
      done_r <= done_nxt;
      wsum_r <= wsum_nxt;
      tsum_r <= tsum_nxt;
      rsum_r <= rsum_nxt;
      if (cfg_valid && cfg_ready) begin
        policy_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= in_command;
      tag_r <= in_job_tag;
      now_r <= in_now;
    end
    if (load_out) begin
      ostat_r <= res_status_r;
      orv_r <= res_rv_r;
      otag_r <= res_tag_r;
      ocnt_r <= done_r;
      owsum_r <= wsum_r;
      otsum_r <= tsum_r;
      orsum_r <= rsum_r;
    end
    cnt_r <= cnt_nxt;
    found_r <= found_nxt;
    hit_r <= hit_nxt;
    best_ok_r <= best_ok_nxt;
    best_r <= best_nxt;
    bkey_r <= bkey_nxt;
    barr_r <= barr_nxt;
    res_status_r <= res_status_nxt;
    res_rv_r <= res_rv_nxt;
    res_tag_r <= res_tag_nxt;
  end
endmodule

FILE: hw/rtl/jss_ram.sv
`timescale 1ns / 1ps
module jss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/jss_checker.sv
`timescale 1ns / 1ps
`include "job_scheduler_select_unit_assert.svh"
module jss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_run_valid,
  input logic [15:0] out_run_tag,
  input logic [31:0] out_finished_count
);
  `JSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_run_tag))
  `JSS_ASSERT_IMPL(a_status_code, out_valid, out_status != 2'd3)
  `JSS_ASSERT_IMPL(a_err_no_run, out_valid && out_status != jss_pkg::ST_OK, !out_run_valid)
  `JSS_ASSERT_IMPL(a_idle_tag, out_valid && !out_run_valid, out_run_tag == 16'd0)
  `JSS_ASSERT_NEXT(a_count_mono, out_valid && !out_stall,
                   out_finished_count == $past(out_finished_count) ||
                   out_finished_count == $past(out_finished_count) + 32'd1)
endmodule

bind job_scheduler_select_unit jss_checker u_jss_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_run_valid(out_run_valid), .out_run_tag(out_run_tag),
  .out_finished_count(out_finished_count)
);
